### rtl/core/afc_pkg.sv
`default_nettype none

package afc_pkg;

    // default converter resolution
    localparam int RES_BITS_DEF = 10;

    // configuration bus address width (seven word registers)
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FILTER_WEIGHT = 3'd0,
        REG_LOW_END       = 3'd1,
        REG_CENTER_POINT  = 3'd2,
        REG_HIGH_END      = 3'd3,
        REG_AXIS_ENABLED  = 3'd4,
        REG_INVERT_OUTPUT = 3'd5,
        REG_CENTERED_MODE = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_F,
        ST_DIV_F,
        ST_LEVEL,
        ST_MUL_M,
        ST_DIV_M,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_FILT,
        DP_DIV_STEP,
        DP_LEVEL,
        DP_MUL_MAP,
        DP_FINISH
    } t_dp_op;

    typedef enum logic [2:0] {
        CLS_DIS,
        CLS_LOW,
        CLS_HIGH,
        CLS_CENTER,
        CLS_MAP_LO,
        CLS_MAP_HI,
        CLS_LIN
    } t_cls;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/afc_regs.sv
`default_nettype none

module afc_regs
    import afc_pkg::*;
#(
    parameter int RESOLUTION_BITS = RES_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [RESOLUTION_BITS-1:0] o_filter_weight,
    output logic      [RESOLUTION_BITS-1:0] o_low_end,
    output logic      [RESOLUTION_BITS-1:0] o_center_point,
    output logic      [RESOLUTION_BITS-1:0] o_high_end,
    output logic                            o_axis_enabled,
    output logic                            o_invert_output,
    output logic                            o_centered_mode
);

    localparam int W = RESOLUTION_BITS;
    localparam logic [W-1:0] FULL = {W{1'b1}};
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] r_filter_weight;
    logic [W-1:0] r_low_end;
    logic [W-1:0] r_center_point;
    logic [W-1:0] r_high_end;
    logic         r_axis_enabled;
    logic         r_invert_output;
    logic         r_centered_mode;
    logic         wr_en;
    t_reg_idx     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_weight <= W'(7);
            r_low_end       <= W'(1);
            r_center_point  <= HALF;
            r_high_end      <= FULL - W'(1);
            r_axis_enabled  <= 1'b1;
            r_invert_output <= 1'b0;
            r_centered_mode <= 1'b1;
        end else if (wr_en) begin
            case (idx)
                REG_FILTER_WEIGHT: r_filter_weight <= pwdata[W-1:0];
                REG_LOW_END:       r_low_end       <= pwdata[W-1:0];
                REG_CENTER_POINT:  r_center_point  <= pwdata[W-1:0];
                REG_HIGH_END:      r_high_end      <= pwdata[W-1:0];
                REG_AXIS_ENABLED:  r_axis_enabled  <= pwdata[0];
                REG_INVERT_OUTPUT: r_invert_output <= pwdata[0];
                REG_CENTERED_MODE: r_centered_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FILTER_WEIGHT: prdata = 32'(r_filter_weight);
            REG_LOW_END:       prdata = 32'(r_low_end);
            REG_CENTER_POINT:  prdata = 32'(r_center_point);
            REG_HIGH_END:      prdata = 32'(r_high_end);
            REG_AXIS_ENABLED:  prdata = 32'(r_axis_enabled);
            REG_INVERT_OUTPUT: prdata = 32'(r_invert_output);
            REG_CENTERED_MODE: prdata = 32'(r_centered_mode);
            default:           prdata = 32'd0;
        endcase
    end

    assign o_filter_weight = r_filter_weight;
    assign o_low_end       = r_low_end;
    assign o_center_point  = r_center_point;
    assign o_high_end      = r_high_end;
    assign o_axis_enabled  = r_axis_enabled;
    assign o_invert_output = r_invert_output;
    assign o_centered_mode = r_centered_mode;

endmodule

`default_nettype wire

### rtl/core/afc_ctrl.sv
`default_nettype none

module afc_ctrl
    import afc_pkg::*;
#(
    parameter int RESOLUTION_BITS = RES_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam int W  = RESOLUTION_BITS;
    localparam int CW = $clog2(W);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          cnt_last;
    logic          out_free;

    assign cnt_last = (r_cnt == CW'(W - 1));
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = DP_NOP;
        o_in_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = ST_MUL_F;
                end
            end
            ST_MUL_F: begin
                o_cmd.op = DP_MUL_FILT;
                n_cnt    = '0;
                n_state  = ST_DIV_F;
            end
            ST_DIV_F: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                o_cmd.op = DP_LEVEL;
                n_state  = i_stat.need_div ? ST_MUL_M : ST_FINISH;
            end
            ST_MUL_M: begin
                o_cmd.op = DP_MUL_MAP;
                n_cnt    = '0;
                n_state  = ST_DIV_M;
            end
            ST_DIV_M: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.op    = DP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/afc_dp.sv
`default_nettype none

module afc_dp
    import afc_pkg::*;
#(
    parameter int RESOLUTION_BITS = RES_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic [RESOLUTION_BITS-1:0] i_sample,
    input  wire logic [RESOLUTION_BITS-1:0] i_filter_weight,
    input  wire logic [RESOLUTION_BITS-1:0] i_low_end,
    input  wire logic [RESOLUTION_BITS-1:0] i_center_point,
    input  wire logic [RESOLUTION_BITS-1:0] i_high_end,
    input  wire logic                       i_axis_enabled,
    input  wire logic                       i_invert_output,
    input  wire logic                       i_centered_mode,
    output logic      [RESOLUTION_BITS-1:0] o_axis_value,
    output logic      [RESOLUTION_BITS-1:0] o_level
);

    localparam int W = RESOLUTION_BITS;
    localparam logic [W-1:0] FULL = {W{1'b1}};
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   r_sample;
    logic [W-1:0]   r_level;
    logic [W-1:0]   r_axis;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_quo;
    logic [W:0]     r_div;
    logic [W-1:0]   r_mdiff;
    t_cls           r_cls;
    logic [W-1:0]   r_out_axis;
    logic [W-1:0]   r_out_level;

    logic [W-1:0]   mul_a, mul_b, mul_add;
    logic [2*W-1:0] mul_num;
    logic [W:0]     trial, trial_sub;
    logic           trial_ge;
    logic [W-1:0]   lvl;
    t_cls           cls;
    logic [W-1:0]   mdiff, mdiv;
    logic [W-1:0]   t_map, t_fin, delta;
    logic [W:0]     sum;
    logic [W-1:0]   n_axis;

    // shared multiplier: filter numerator or mapping numerator
    always_comb begin
        if (i_cmd.op == DP_MUL_FILT) begin
            mul_a   = i_filter_weight;
            mul_b   = r_level;
            mul_add = r_sample;
        end else begin
            mul_a   = (r_cls == CLS_LIN) ? FULL : HALF;
            mul_b   = r_mdiff;
            mul_add = '0;
        end
        mul_num = ({{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b}) + {{W{1'b0}}, mul_add};
    end

    // restoring divider, one quotient bit per cycle; quotient always fits W bits
    assign trial     = {r_rem, r_quo[W-1]};
    assign trial_ge  = (trial >= r_div);
    assign trial_sub = trial - r_div;

    // classification of the new level
    assign lvl = r_quo;
    always_comb begin
        mdiff = lvl - i_low_end;
        mdiv  = i_high_end - i_low_end;
        if (!i_axis_enabled) begin
            cls = CLS_DIS;
        end else if (lvl <= i_low_end) begin
            cls = CLS_LOW;
        end else if (lvl >= i_high_end) begin
            cls = CLS_HIGH;
        end else if (i_centered_mode) begin
            if (lvl < i_center_point) begin
                cls  = CLS_MAP_LO;
                mdiv = i_center_point - i_low_end;
            end else if (lvl > i_center_point) begin
                cls   = CLS_MAP_HI;
                mdiff = lvl - i_center_point;
                mdiv  = i_high_end - i_center_point;
            end else begin
                cls = CLS_CENTER;
            end
        end else begin
            cls = CLS_LIN;
        end
        o_stat.need_div = (cls inside {CLS_MAP_LO, CLS_MAP_HI, CLS_LIN});
    end

    // final mapping, mirror and averaging
    always_comb begin
        if (r_cls == CLS_CENTER) begin
            t_map = HALF;
        end else if (r_cls == CLS_MAP_HI) begin
            t_map = HALF + r_quo;
        end else begin
            t_map = r_quo;
        end
        t_fin = i_invert_output ? (FULL - t_map) : t_map;
        delta = (r_axis > t_fin) ? (r_axis - t_fin) : (t_fin - r_axis);
        sum   = {1'b0, r_axis} + {1'b0, t_fin};
        case (r_cls)
            CLS_DIS:  n_axis = HALF;
            CLS_LOW:  n_axis = i_invert_output ? FULL : '0;
            CLS_HIGH: n_axis = i_invert_output ? '0 : FULL;
            default:  n_axis = (delta > W'(1)) ? sum[W:1] : r_axis;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_axis  <= '0;
        end else begin
            if (i_cmd.op == DP_LEVEL) begin
                r_level <= lvl;
            end
            if (i_cmd.op == DP_FINISH) begin
                r_axis <= n_axis;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_sample <= i_sample;
            end
            DP_MUL_FILT: begin
                r_rem <= mul_num[2*W-1:W];
                r_quo <= mul_num[W-1:0];
                r_div <= {1'b0, i_filter_weight} + (W+1)'(1);
            end
            DP_MUL_MAP: begin
                r_rem <= mul_num[2*W-1:W];
                r_quo <= mul_num[W-1:0];
            end
            DP_DIV_STEP: begin
                r_rem <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
                r_quo <= {r_quo[W-2:0], trial_ge};
            end
            DP_LEVEL: begin
                r_cls   <= cls;
                r_mdiff <= mdiff;
                r_div   <= {1'b0, mdiv};
            end
            DP_FINISH: begin
                r_out_axis  <= n_axis;
                r_out_level <= r_level;
            end
            default: ;
        endcase
    end

    assign o_axis_value = r_out_axis;
    assign o_level      = r_out_level;

endmodule

`default_nettype wire

### rtl/core/axis_filter_calibrate.sv
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_sample
// output    out        o_out_valid / i_out_stall o_axis_value, o_level
// config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one sample at a time; a shared restoring divider makes one quotient bit per cycle
// mapped level, from accept to next accept: load, filter multiply, filter division, level,
// mapping multiply, mapping division, finish; disabled, clamped or centre level skip the mapping steps
// synchronous active-low reset clears the filter level, the averaged axis, the output valid and the control
// a result waits in the output register under stall while the next sample is accepted
`default_nettype none

module axis_filter_calibrate
    import afc_pkg::*;
#(
    parameter int RESOLUTION_BITS = RES_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [RESOLUTION_BITS-1:0] i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [RESOLUTION_BITS-1:0] o_axis_value,
    output logic      [RESOLUTION_BITS-1:0] o_level,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    localparam int W = RESOLUTION_BITS;

    logic [W-1:0] filter_weight;
    logic [W-1:0] low_end;
    logic [W-1:0] center_point;
    logic [W-1:0] high_end;
    logic         axis_enabled;
    logic         invert_output;
    logic         centered_mode;
    t_dp_cmd      dp_cmd;
    t_dp_stat     dp_stat;

    afc_regs #(
        .RESOLUTION_BITS(RESOLUTION_BITS)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_filter_weight (filter_weight),
        .o_low_end       (low_end),
        .o_center_point  (center_point),
        .o_high_end      (high_end),
        .o_axis_enabled  (axis_enabled),
        .o_invert_output (invert_output),
        .o_centered_mode (centered_mode)
    );

    afc_ctrl #(
        .RESOLUTION_BITS(RESOLUTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    afc_dp #(
        .RESOLUTION_BITS(RESOLUTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_sample        (i_sample),
        .i_filter_weight (filter_weight),
        .i_low_end       (low_end),
        .i_center_point  (center_point),
        .i_high_end      (high_end),
        .i_axis_enabled  (axis_enabled),
        .i_invert_output (invert_output),
        .i_centered_mode (centered_mode),
        .o_axis_value    (o_axis_value),
        .o_level         (o_level)
    );

endmodule

`default_nettype wire

### rtl/core/afc_chk.sv
`default_nettype none

module afc_chk
    import afc_pkg::*;
#(
    parameter int RESOLUTION_BITS = RES_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       o_in_stall,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [RESOLUTION_BITS-1:0] o_axis_value,
    input  wire logic [RESOLUTION_BITS-1:0] o_level
);

    // result held while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_axis_value) && $stable(o_level))
        else $error("output transaction changed under stall");

    // one sample in flight: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a sample is in work");

    // a result only appears at the end of a busy phase
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output valid rose without work");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind axis_filter_calibrate afc_chk #(
    .RESOLUTION_BITS(RESOLUTION_BITS)
) u_afc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_axis_value (o_axis_value),
    .o_level      (o_level)
);

`default_nettype wire
